// ===== rtl/cbf_pkg.sv =====
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared constants and the result record of the camera basis block.
// ----------------------------------------------------------------------------
package cbf_pkg;

    localparam int IN_WIDTH_DEF  = 16;
    localparam int FRAC_BITS_DEF = 14;

    // Result fields are 16 bits wide whatever the internal precision.
    localparam int OUT_W = 16;

    localparam int                 THR_W     = 15;
    localparam logic [THR_W-1:0]   THR_RESET = 15'd16368;

    typedef struct packed {
        logic [2:0][OUT_W-1:0] front;
        logic [2:0][OUT_W-1:0] side;
        logic [2:0][OUT_W-1:0] above;
        logic                  flipped;
        logic                  alt_up;
        logic                  zero_forward;
    } t_result;

endpackage

// ===== rtl/cbf_norm.sv =====
// ----------------------------------------------------------------------------
// cbf_norm
// Pipelined normalisation of a three-component vector to unit length in
// Q1.FRAC_BITS: squares, sum, a bit-per-stage square root and three
// bit-per-stage restoring dividers. A side-band word travels alongside.
// ----------------------------------------------------------------------------
module cbf_norm #(
    parameter int VW        = 16,
    parameter int MAG_EXP   = 15,
    parameter int FRAC_BITS = 14,
    parameter int SB_W      = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [VW-1:0]        i_v [3],
    input  logic [SB_W-1:0]             i_sb,
    output logic                        o_valid,
    output logic signed [FRAC_BITS+1:0] o_u [3],
    output logic                        o_nonzero,
    output logic [SB_W-1:0]             o_sb
);

    localparam int G      = (MAG_EXP < 30) ? 30 - MAG_EXP : 0;
    localparam int MW     = MAG_EXP + 1;
    localparam int SW     = 2 * MAG_EXP + 2;
    localparam int RW     = SW + 2 * G;
    localparam int LW     = RW / 2;
    localparam int RMW    = LW + 3;
    localparam int QW     = FRAC_BITS + 2;
    localparam int DW     = MAG_EXP + FRAC_BITS + G + 3;
    localparam int NUM_SH = FRAC_BITS + G + 1;
    localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

    // Stage 0: magnitudes and squares.
    logic [MW-1:0]   n_mag [3];
    logic [SW-1:0]   n_sq  [3];
    logic            r0_v;
    logic [MW-1:0]   r0_m  [3];
    logic [SW-1:0]   r0_sq [3];
    logic [2:0]      r0_sn;
    logic [SB_W-1:0] r0_sb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = MW'(i_v[i] < 0 ? -i_v[i] : i_v[i]);
            n_sq[i]  = SW'(n_mag[i]) * SW'(n_mag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r0_m[i]  <= n_mag[i];
                r0_sq[i] <= n_sq[i];
                r0_sn[i] <= i_v[i][VW-1];
            end
            r0_sb <= i_sb;
        end
    end

    // Square-root pipeline; index 0 holds the scaled sum of squares.
    logic            s_v  [LW+1];
    logic [LW-1:0]   s_rt [LW+1];
    logic [RMW-1:0]  s_rm [LW+1];
    logic [RW-1:0]   s_rr [LW+1];
    logic [MW-1:0]   s_m  [LW+1][3];
    logic [2:0]      s_sn [LW+1];
    logic            s_z  [LW+1];
    logic [SB_W-1:0] s_sb [LW+1];
    logic [SW-1:0]   n_sum;

    assign n_sum = r0_sq[0] + r0_sq[1] + r0_sq[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_v[0] <= 1'b0;
        end else if (i_en) begin
            s_v[0] <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            s_rt[0] <= '0;
            s_rm[0] <= '0;
            s_rr[0] <= RW'(n_sum) << (2 * G);
            s_z[0]  <= (n_sum == '0);
            s_m[0]  <= r0_m;
            s_sn[0] <= r0_sn;
            s_sb[0] <= r0_sb;
        end
    end

    for (genvar j = 0; j < LW; j++) begin : g_sqrt
        logic [RMW-1:0] n_rmx;
        logic [RMW-1:0] n_trial;
        logic           n_ge;

        // Bring down the next two radicand bits and try a one in this root bit.
        assign n_rmx   = {s_rm[j][LW:0], s_rr[j][RW-1 -: 2]};
        assign n_trial = RMW'({s_rt[j], 2'b01});
        assign n_ge    = (n_rmx >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_v[j+1] <= 1'b0;
            end else if (i_en) begin
                s_v[j+1] <= s_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                s_rt[j+1] <= {s_rt[j][LW-2:0], n_ge};
                s_rm[j+1] <= n_ge ? n_rmx - n_trial : n_rmx;
                s_rr[j+1] <= s_rr[j] << 2;
                s_m[j+1]  <= s_m[j];
                s_sn[j+1] <= s_sn[j];
                s_z[j+1]  <= s_z[j];
                s_sb[j+1] <= s_sb[j];
            end
        end
    end

    // Division pipeline; index 0 holds the rounded dividends.
    logic            d_v   [QW+1];
    logic [DW-1:0]   d_rem [QW+1][3];
    logic [QW-1:0]   d_q   [QW+1][3];
    logic [LW:0]     d_den [QW+1];
    logic [2:0]      d_sn  [QW+1];
    logic            d_z   [QW+1];
    logic [SB_W-1:0] d_sb  [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            d_v[0] <= 1'b0;
        end else if (i_en) begin
            d_v[0] <= s_v[LW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                // Adding the root before dividing by twice the root rounds half away.
                d_rem[0][i] <= (DW'(s_m[LW][i]) << NUM_SH) + DW'(s_rt[LW]);
                d_q[0][i]   <= '0;
            end
            d_den[0] <= {s_rt[LW], 1'b0};
            d_sn[0]  <= s_sn[LW];
            d_z[0]   <= s_z[LW];
            d_sb[0]  <= s_sb[LW];
        end
    end

    for (genvar t = 0; t < QW; t++) begin : g_div
        localparam int BIT = QW - 1 - t;
        logic [2:0] n_ge;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                n_ge[i] = ((d_rem[t][i] >> BIT) >= DW'(d_den[t]));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                d_v[t+1] <= 1'b0;
            end else if (i_en) begin
                d_v[t+1] <= d_v[t];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    d_rem[t+1][i] <= n_ge[i] ? d_rem[t][i] - (DW'(d_den[t]) << BIT)
                                             : d_rem[t][i];
                    d_q[t+1][i]   <= {d_q[t][i][QW-2:0], n_ge[i]};
                end
                d_den[t+1] <= d_den[t];
                d_sn[t+1]  <= d_sn[t];
                d_z[t+1]   <= d_z[t];
                d_sb[t+1]  <= d_sb[t];
            end
        end
    end

    // Final stage: clamp, apply sign, zero out a zero-length vector.
    logic [QW-1:0]              n_cl [3];
    logic                       r_v;
    logic signed [QW-1:0]       r_u  [3];
    logic                       r_nz;
    logic [SB_W-1:0]            r_sb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_cl[i] = (d_q[QW][i] > ONE) ? ONE : d_q[QW][i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= d_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (d_z[QW]) begin
                    r_u[i] <= '0;
                end else if (d_sn[QW][i]) begin
                    r_u[i] <= -$signed(n_cl[i]);
                end else begin
                    r_u[i] <= $signed(n_cl[i]);
                end
            end
            r_nz <= !d_z[QW];
            r_sb <= d_sb[QW];
        end
    end

    assign o_valid   = r_v;
    assign o_u       = r_u;
    assign o_nonzero = r_nz;
    assign o_sb      = r_sb;

endmodule

// ===== rtl/camera_basis_from_forward_core.sv =====
// ----------------------------------------------------------------------------
// camera_basis_from_forward_core
// Builds forward, right and up unit vectors in Q1.FRAC_BITS from a forward
// vector and a vector toward a point.
// ----------------------------------------------------------------------------
// The input channel (i_in_valid / o_in_ready) carries one forward vector and
// one target vector per transfer; the output channel (o_out_valid /
// i_out_ready) returns the basis and three flags per transfer, in order.
// The world-up threshold is written through i_cfg_we / i_cfg_wdata; the user
// must write it only while the block is idle (the block does not enforce it).
// One item is accepted every cycle while o_in_ready is high. Each normaliser
// has a square-root pipeline LW bits wide (one root bit per stage) and a
// divider pipeline of length QW = FRAC_BITS+2 (one quotient bit per stage).
// Reset empties the pipeline and restores the threshold to 16368.
// When the receiver stalls, the result waits in the output register and one
// further result is caught in a skid register; only then does the pipeline
// freeze and o_in_ready fall.
// ----------------------------------------------------------------------------
module camera_basis_from_forward_core #(
    parameter int IN_WIDTH  = cbf_pkg::IN_WIDTH_DEF,
    parameter int FRAC_BITS = cbf_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cbf_pkg::THR_W-1:0]      i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [IN_WIDTH-1:0]     i_fwd_x,
    input  logic signed [IN_WIDTH-1:0]     i_fwd_y,
    input  logic signed [IN_WIDTH-1:0]     i_fwd_z,
    input  logic signed [IN_WIDTH-1:0]     i_target_x,
    input  logic signed [IN_WIDTH-1:0]     i_target_y,
    input  logic signed [IN_WIDTH-1:0]     i_target_z,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [cbf_pkg::OUT_W-1:0] o_front_x,
    output logic signed [cbf_pkg::OUT_W-1:0] o_front_y,
    output logic signed [cbf_pkg::OUT_W-1:0] o_front_z,
    output logic signed [cbf_pkg::OUT_W-1:0] o_side_x,
    output logic signed [cbf_pkg::OUT_W-1:0] o_side_y,
    output logic signed [cbf_pkg::OUT_W-1:0] o_side_z,
    output logic signed [cbf_pkg::OUT_W-1:0] o_above_x,
    output logic signed [cbf_pkg::OUT_W-1:0] o_above_y,
    output logic signed [cbf_pkg::OUT_W-1:0] o_above_z,
    output logic                           o_flipped,
    output logic                           o_alt_up,
    output logic                           o_zero_forward
);
    import cbf_pkg::*;

    localparam int OW   = FRAC_BITS + 2;
    localparam int PDW  = IN_WIDTH + OW;
    localparam int DTW  = PDW + 2;
    localparam int PW   = 2 * OW;
    localparam int XW   = PW + 1;
    localparam int CMPW = (FRAC_BITS + 1 > THR_W) ? FRAC_BITS + 1 : THR_W;
    localparam int SB1W = 3 * IN_WIDTH;
    localparam int SB2W = 3 * OW + 3;

    logic             w_en;
    logic [THR_W-1:0] r_thr;

    // The pipeline moves whenever the skid register is free.
    logic             r_sk_v;
    assign w_en       = !r_sk_v;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // First normalisation: the forward vector, with the target riding along.
    logic signed [IN_WIDTH-1:0] w_fwd [3];
    logic                       w1_v;
    logic signed [OW-1:0]       w1_f [3];
    logic                       w1_nz;
    logic [SB1W-1:0]            w1_sb;

    assign w_fwd[0] = i_fwd_x;
    assign w_fwd[1] = i_fwd_y;
    assign w_fwd[2] = i_fwd_z;

    cbf_norm #(
        .VW        (IN_WIDTH),
        .MAG_EXP   (IN_WIDTH - 1),
        .FRAC_BITS (FRAC_BITS),
        .SB_W      (SB1W)
    ) u_norm_fwd (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_in_valid),
        .i_v       (w_fwd),
        .i_sb      ({i_target_z, i_target_y, i_target_x}),
        .o_valid   (w1_v),
        .o_u       (w1_f),
        .o_nonzero (w1_nz),
        .o_sb      (w1_sb)
    );

    // P1: dot-product terms and the world-up choice.
    logic                  r_p1_v;
    logic signed [OW-1:0]  r_p1_f  [3];
    logic signed [PDW-1:0] r_p1_dp [3];
    logic                  r_p1_alt;
    logic                  r_p1_nz;
    logic [OW-1:0]         n_fz_abs;

    assign n_fz_abs = (w1_f[2] < 0) ? -w1_f[2] : w1_f[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= w1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p1_f[i]  <= w1_f[i];
                r_p1_dp[i] <= $signed(w1_sb[i*IN_WIDTH +: IN_WIDTH]) * w1_f[i];
            end
            r_p1_alt <= (CMPW'(n_fz_abs) > CMPW'(r_thr));
            r_p1_nz  <= w1_nz;
        end
    end

    // P2: flip toward the target and form forward cross world-up.
    logic signed [DTW-1:0] n_dot;
    logic                  n_flip;
    logic signed [OW-1:0]  n_f2 [3];
    logic                  r_p2_v;
    logic signed [OW-1:0]  r_p2_c [3];
    logic [SB2W-1:0]       r_p2_sb;

    assign n_dot  = DTW'(r_p1_dp[0]) + DTW'(r_p1_dp[1]) + DTW'(r_p1_dp[2]);
    assign n_flip = r_p1_nz && (n_dot < 0);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_f2[i] = n_flip ? -r_p1_f[i] : r_p1_f[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (w_en) begin
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_p1_alt) begin
                r_p2_c[0] <= -n_f2[2];
                r_p2_c[1] <= '0;
                r_p2_c[2] <= n_f2[0];
            end else begin
                r_p2_c[0] <= n_f2[1];
                r_p2_c[1] <= -n_f2[0];
                r_p2_c[2] <= '0;
            end
            r_p2_sb <= {n_f2[2], n_f2[1], n_f2[0], n_flip, r_p1_alt, !r_p1_nz};
        end
    end

    // Second normalisation: the right vector, with forward and flags along.
    logic                 w2_v;
    logic signed [OW-1:0] w2_r [3];
    logic                 w2_nz;
    logic [SB2W-1:0]      w2_sb;
    logic signed [OW-1:0] w2_f [3];

    cbf_norm #(
        .VW        (OW),
        .MAG_EXP   (FRAC_BITS),
        .FRAC_BITS (FRAC_BITS),
        .SB_W      (SB2W)
    ) u_norm_side (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r_p2_v),
        .i_v       (r_p2_c),
        .i_sb      (r_p2_sb),
        .o_valid   (w2_v),
        .o_u       (w2_r),
        .o_nonzero (w2_nz),
        .o_sb      (w2_sb)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w2_f[i] = $signed(w2_sb[3 + i*OW +: OW]);
        end
    end

    // P3: the six products of right cross forward.
    logic                 r_p3_v;
    logic signed [PW-1:0] r_p3_pr [6];
    logic signed [OW-1:0] r_p3_f  [3];
    logic signed [OW-1:0] r_p3_r  [3];
    logic [2:0]           r_p3_fl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else if (w_en) begin
            r_p3_v <= w2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3_pr[0] <= w2_r[1] * w2_f[2];
            r_p3_pr[1] <= w2_r[2] * w2_f[1];
            r_p3_pr[2] <= w2_r[2] * w2_f[0];
            r_p3_pr[3] <= w2_r[0] * w2_f[2];
            r_p3_pr[4] <= w2_r[0] * w2_f[1];
            r_p3_pr[5] <= w2_r[1] * w2_f[0];
            // A zero cross product already gives a zero right vector.
            for (int i = 0; i < 3; i++) begin
                r_p3_r[i] <= w2_nz ? w2_r[i] : '0;
            end
            r_p3_f     <= w2_f;
            r_p3_fl    <= w2_sb[2:0];
        end
    end

    // P4: round the up vector back to Q1.FRAC_BITS.
    function automatic logic signed [OW-1:0] round_frac(input logic signed [XW-1:0] p);
        logic [XW-1:0] mag;
        logic [XW-1:0] m;
        mag = (p < 0) ? XW'(-p) : XW'(p);
        m   = (mag + (XW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (m > (XW'(1) << FRAC_BITS)) begin
            m = XW'(1) << FRAC_BITS;
        end
        return (p < 0) ? -$signed(OW'(m)) : $signed(OW'(m));
    endfunction

    logic signed [XW-1:0] n_d [3];
    logic                 r_p4_v;
    t_result              r_p4;

    assign n_d[0] = XW'(r_p3_pr[0]) - XW'(r_p3_pr[1]);
    assign n_d[1] = XW'(r_p3_pr[2]) - XW'(r_p3_pr[3]);
    assign n_d[2] = XW'(r_p3_pr[4]) - XW'(r_p3_pr[5]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_v <= 1'b0;
        end else if (w_en) begin
            r_p4_v <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p4.front[i] <= OUT_W'(r_p3_f[i]);
                r_p4.side[i]  <= OUT_W'(r_p3_r[i]);
                r_p4.above[i] <= OUT_W'(round_frac(n_d[i]));
            end
            r_p4.flipped      <= r_p3_fl[2];
            r_p4.alt_up       <= r_p3_fl[1];
            r_p4.zero_forward <= r_p3_fl[0];
        end
    end

    // Output register with a skid register behind it.
    logic    w_take;
    logic    r_out_v;
    t_result r_out;
    t_result r_sk;

    assign w_take = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (w_take) begin
            if (r_sk_v) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end else begin
                r_out_v <= r_p4_v;
            end
        end else if (r_p4_v && !r_sk_v) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= r_sk_v ? r_sk : r_p4;
        end
        if (!w_take && !r_sk_v) begin
            r_sk <= r_p4;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_front_x      = $signed(r_out.front[0]);
    assign o_front_y      = $signed(r_out.front[1]);
    assign o_front_z      = $signed(r_out.front[2]);
    assign o_side_x       = $signed(r_out.side[0]);
    assign o_side_y       = $signed(r_out.side[1]);
    assign o_side_z       = $signed(r_out.side[2]);
    assign o_above_x      = $signed(r_out.above[0]);
    assign o_above_y      = $signed(r_out.above[1]);
    assign o_above_z      = $signed(r_out.above[2]);
    assign o_flipped      = r_out.flipped;
    assign o_alt_up       = r_out.alt_up;
    assign o_zero_forward = r_out.zero_forward;

endmodule
